>>> rtl/core/lest_pkg.sv
package lest_pkg;

    // defaults for the top level parameters
    localparam int TABLE_DEPTH_DEFAULT = 64;
    localparam int LIGHT_COUNT_DEFAULT = 32;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input op codes
    localparam logic [2:0] OP_SCHED_ON  = 3'd0;
    localparam logic [2:0] OP_SCHED_OFF = 3'd1;
    localparam logic [2:0] OP_REMOVE    = 3'd2;
    localparam logic [2:0] OP_RANDOMIZE = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OOB  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        CMD_REPLY,
        CMD_SCHED,
        CMD_REMOVE,
        CMD_RAND,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  status;
        logic [7:0]  light;
        logic [3:0]  day;
        logic [10:0] minute;
        logic [6:0]  offset;
        logic        turn_on;
        logic [2:0]  now_day;
        logic [10:0] now_minute;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  light;
        logic [3:0]  day;
        logic [10:0] minute;
        logic        turn_on;
        logic [6:0]  offset;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [7:0] cmd_light;
        logic       turn_on;
        logic       last;
    } result_t;

endpackage

>>> rtl/core/lest_ram.sv
module lest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lest_front.sv
module lest_front #(
    parameter int LIGHT_COUNT = lest_pkg::LIGHT_COUNT_DEFAULT
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lest_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [lest_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output lest_pkg::cmd_t                q_cmd
);

    logic [2:0] op;
    logic [7:0] light_id;
    logic       light_bad;

    assign op       = s_tuser[2:0];
    assign light_id = s_tdata[7:0];
    assign light_bad = ({1'b0, light_id} >= 9'(LIGHT_COUNT));

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_cmd            = '0;
        q_cmd.light      = light_id;
        q_cmd.day        = s_tdata[11:8];
        q_cmd.minute     = s_tdata[22:12];
        q_cmd.offset     = s_tdata[29:23];
        q_cmd.now_day    = s_tdata[32:30];
        q_cmd.now_minute = s_tdata[43:33];
        q_cmd.status     = lest_pkg::STATUS_OK;
        q_cmd.turn_on    = (op == lest_pkg::OP_SCHED_ON);
        unique case (op) inside
            lest_pkg::OP_SCHED_ON, lest_pkg::OP_SCHED_OFF:
            begin
                if (light_bad)
                begin
                    q_cmd.kind   = lest_pkg::CMD_REPLY;
                    q_cmd.status = lest_pkg::STATUS_OOB;
                end
                else
                begin
                    q_cmd.kind = lest_pkg::CMD_SCHED;
                end
            end
            lest_pkg::OP_REMOVE:    q_cmd.kind = lest_pkg::CMD_REMOVE;
            lest_pkg::OP_RANDOMIZE: q_cmd.kind = lest_pkg::CMD_RAND;
            lest_pkg::OP_TICK:      q_cmd.kind = lest_pkg::CMD_TICK;
            default:                q_cmd.kind = lest_pkg::CMD_REPLY;
        endcase
    end

endmodule

>>> rtl/core/lest_queue.sv
module lest_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lest_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output lest_pkg::cmd_t head
);

    localparam int PTR_W = (lest_pkg::QUEUE_DEPTH > 1) ? $clog2(lest_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lest_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lest_pkg::QUEUE_DEPTH - 1);

    lest_pkg::cmd_t   slots_reg [lest_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(lest_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/lest_back.sv
module lest_back #(
    parameter int TABLE_DEPTH = lest_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  lest_pkg::cmd_t    q_cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output lest_pkg::result_t res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } bstate_t;

    function automatic logic day_responds(input logic [3:0] code, input logic [2:0] today);
        logic hit;
        hit = (code == 4'd7) || (code == {1'b0, today});
        hit = hit || ((code == 4'd9) && ((today == 3'd0) || (today == 3'd6)));
        hit = hit || ((code == 4'd8) && (today >= 3'd1) && (today <= 3'd5));
        return hit;
    endfunction

    bstate_t           state_reg, state_next;
    lest_pkg::cmd_t    cmd_reg;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              pend_reg, pend_next;
    logic              issued_reg, issued_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [7:0]        hold_light_reg;
    logic              hold_on_reg;
    logic              hold_load;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic              out_valid_reg;
    lest_pkg::result_t out_reg;

    logic              out_free;
    logic              emit_en;
    lest_pkg::result_t emit_res;

    logic                          rd_en;
    logic [lest_pkg::ENTRY_W-1:0]  rd_data;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    lest_pkg::entry_t              wr_entry;
    lest_pkg::entry_t              entry;

    logic        ent_valid;
    logic        match_hit;
    logic [11:0] due_sum;
    logic        due_hit;
    logic        is_tick;
    logic        check_stall;
    logic        advance;
    logic        issue;

    lest_ram #(
        .WIDTH (lest_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    assign entry     = lest_pkg::entry_t'(rd_data);
    assign ent_valid = valid_reg[pidx_reg];
    assign match_hit = ent_valid && (entry.light == cmd_reg.light)
                       && (entry.day == cmd_reg.day) && (entry.minute == cmd_reg.minute);
    assign due_sum   = {1'b0, entry.minute} + {{5{entry.offset[6]}}, entry.offset};
    assign due_hit   = ent_valid && (due_sum == {1'b0, cmd_reg.now_minute})
                       && day_responds(entry.day, cmd_reg.now_day);
    assign is_tick   = (cmd_reg.kind == lest_pkg::CMD_TICK);
    assign out_free  = !out_valid_reg || res_ready;
    assign check_stall = pend_reg && is_tick && due_hit && hold_valid_reg && !out_free;
    assign advance   = !check_stall;
    assign issue     = advance && !issued_reg;

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        pend_next       = pend_reg;
        issued_next     = issued_reg;
        hold_valid_next = hold_valid_reg;
        hold_load       = 1'b0;
        valid_next      = valid_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = pidx_reg;
        wr_entry        = entry;
        emit_en         = 1'b0;
        emit_res        = '0;
        emit_res.last   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    status_next     = q_cmd.status;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    issued_next     = 1'b0;
                    hold_valid_next = 1'b0;
                    state_next = (q_cmd.kind == lest_pkg::CMD_REPLY) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmd_reg.kind == lest_pkg::CMD_SCHED)
                begin
                    // walk the valid bits for the lowest free slot
                    if (!valid_reg[idx_reg])
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = idx_reg;
                        wr_entry.light   = cmd_reg.light;
                        wr_entry.day     = cmd_reg.day;
                        wr_entry.minute  = cmd_reg.minute;
                        wr_entry.turn_on = cmd_reg.turn_on;
                        wr_entry.offset  = '0;
                        valid_next[idx_reg] = 1'b1;
                        status_next = lest_pkg::STATUS_OK;
                        state_next  = ST_DONE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        status_next = lest_pkg::STATUS_FULL;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // read one entry a cycle while no tick result stalls, check it from the registered read data
                    if (pend_reg && advance)
                    begin
                        if ((cmd_reg.kind == lest_pkg::CMD_REMOVE) && match_hit)
                        begin
                            valid_next[pidx_reg] = 1'b0;
                        end
                        if ((cmd_reg.kind == lest_pkg::CMD_RAND) && match_hit)
                        begin
                            wr_en           = 1'b1;
                            wr_entry.offset = cmd_reg.offset;
                        end
                        if (is_tick && due_hit)
                        begin
                            if (hold_valid_reg)
                            begin
                                emit_en            = 1'b1;
                                emit_res.kind      = lest_pkg::KIND_CMD;
                                emit_res.cmd_light = hold_light_reg;
                                emit_res.turn_on   = hold_on_reg;
                                emit_res.last      = 1'b0;
                            end
                            hold_load       = 1'b1;
                            hold_valid_next = 1'b1;
                        end
                    end
                    if (advance)
                    begin
                        pend_next = issue;
                    end
                    if (issue)
                    begin
                        rd_en     = 1'b1;
                        pidx_next = idx_reg;
                        idx_next  = idx_reg + 1'b1;
                        if (idx_reg == LAST_IDX)
                        begin
                            issued_next = 1'b1;
                        end
                    end
                    if (!pend_reg && issued_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit_en = 1'b1;
                    if (is_tick)
                    begin
                        if (hold_valid_reg)
                        begin
                            emit_res.kind      = lest_pkg::KIND_CMD;
                            emit_res.cmd_light = hold_light_reg;
                            emit_res.turn_on   = hold_on_reg;
                        end
                        else
                        begin
                            emit_res.kind = lest_pkg::KIND_NONE;
                        end
                    end
                    else
                    begin
                        emit_res.kind   = lest_pkg::KIND_STATUS;
                        emit_res.status = status_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pidx_reg       <= '0;
            pend_reg       <= 1'b0;
            issued_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pidx_reg       <= pidx_next;
            pend_reg       <= pend_next;
            issued_reg     <= issued_next;
            hold_valid_reg <= hold_valid_next;
            valid_reg      <= valid_next;
            if (emit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        status_reg <= status_next;
        if (hold_load)
        begin
            hold_light_reg <= entry.light;
            hold_on_reg    <= entry.turn_on;
        end
        if (emit_en)
        begin
            out_reg <= emit_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> rtl/core/light_event_schedule_table_core.sv
// light event schedule table: keeps up to TABLE_DEPTH events (light, day code, minute,
// on/off, signed offset) and answers each input item on the result stream. schedule
// items fill the lowest free slot, remove and randomize edit every matching entry,
// and a minute tick emits one light command per due entry in index order (tlast on
// the final one) or a single "no command" result. a front stage classifies items and
// checks the light number, a two-entry command queue lets it take the next transfer
// while the back sequencer works. the back walks the table one entry per cycle, when
// no tick result is stalled, through the single read port of the event memory. a tick
// also waits for each command transfer to be taken beyond the one held in the output
// register. reset marks all entries unused at once.
module light_event_schedule_table_core #(
    parameter int TABLE_DEPTH = lest_pkg::TABLE_DEPTH_DEFAULT,
    parameter int LIGHT_COUNT = lest_pkg::LIGHT_COUNT_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // light_id[7:0], day_code[11:8], minute_of_day[22:12], random_offset[29:23],
    // now_day[32:30], now_minute[43:33], zero fill
    input  logic [lest_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[2:0]
    input  logic [lest_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], cmd_light[9:2], turn_on[10], zero fill
    output logic [lest_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [lest_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // final result of an input item
    output logic                           m_axis_tlast
);

    // command path from front to back
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    lest_pkg::cmd_t    push_cmd;
    lest_pkg::cmd_t    head_cmd;
    lest_pkg::result_t res;

    // classify and bounds-check each input transfer
    lest_front #(
        .LIGHT_COUNT(LIGHT_COUNT)
    ) u_front (
        .s_tvalid(s_axis_tvalid),
        .s_tready(s_axis_tready),
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // short queue decouples the front from the table walk
    lest_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (head_cmd)
    );

    // table owner: walks entries and produces result transfers
    lest_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_pop    (q_pop),
        .q_cmd    (head_cmd),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res      (res)
    );

    // pack the result fields onto the master side
    assign m_axis_tdata = {5'b0, res.turn_on, res.cmd_light, res.status};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
